/* design/next_lexicographic_permutation_core_defines.svh */
// Assertion macros shared by the next-permutation core modules.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_CORE_DEFINES_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NLP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NLP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/nlp_pkg.sv */
// Shared types and constants of the next-permutation core.
// No dependencies; used by nlp_engine, nlp_out_reg and the top level.
package nlp_pkg;

  localparam int unsigned SYM_W = 8;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PV_RD,
    ST_PV_CMP,
    ST_J_RD,
    ST_J_CMP,
    ST_SW_I,
    ST_SW_J,
    ST_EM_RD,
    ST_EM_LD,
    ST_NONE
  } nlp_state_e;

  // One result handed from the engine to the output register.
  typedef struct packed {
    logic             load;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             none;
  } nlp_res_t;

endpackage

/* design/nlp_engine.sv */
// Symbol store and sequencer: loads a string, finds pivot and swap partner,
// swaps in memory and reads the result out, or reports that none exists. Depends on nlp_pkg and the defines header.
`include "next_lexicographic_permutation_core_defines.svh"

module nlp_engine #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nlp_pkg::SYM_W-1:0]   in_symbol_i,
  input  logic                        in_last_i,
  input  logic                        slot_free_i,
  output nlp_pkg::nlp_res_t           res_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] OneCnt = CNT_W'(1);
  localparam logic [CNT_W-1:0] TwoCnt = CNT_W'(2);

  nlp_pkg::nlp_state_e state_q, state_d;

  logic [CNT_W-1:0]          cnt_q;
  logic [CNT_W-1:0]          len_q;
  logic [ADDR_W-1:0]         idx_q;
  logic [ADDR_W-1:0]         piv_q;
  logic [ADDR_W-1:0]         j_q;
  logic                      first_q;
  logic [nlp_pkg::SYM_W-1:0] prev_q;
  logic [nlp_pkg::SYM_W-1:0] piv_val_q;
  logic [nlp_pkg::SYM_W-1:0] sj_val_q;

  logic [nlp_pkg::SYM_W-1:0] mem_q [MAX_LEN];
  logic [nlp_pkg::SYM_W-1:0] rdata_q;

  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [nlp_pkg::SYM_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [ADDR_W-1:0]         mem_raddr;

  logic              in_acc;
  logic              has_room;
  logic [CNT_W-1:0]  len_in;
  logic              pv_found;
  logic              j_found;
  logic              em_last;
  logic [CNT_W:0]    rev_sum;
  logic [ADDR_W-1:0] emit_addr;

  assign in_acc   = in_valid_i && in_ready_o;
  assign has_room = cnt_q < MaxCnt;
  assign len_in   = has_room ? cnt_q + OneCnt : cnt_q;
  assign pv_found = !first_q && (rdata_q < prev_q);
  assign j_found  = rdata_q > piv_val_q;
  assign em_last  = CNT_W'(idx_q) == (len_q - OneCnt);

  // Past the pivot the suffix is read back to front, which is the reversal.
  assign rev_sum   = (CNT_W+1)'(len_q) + (CNT_W+1)'(piv_q) - (CNT_W+1)'(idx_q);
  assign emit_addr = (idx_q <= piv_q) ? idx_q : rev_sum[ADDR_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nlp_pkg::ST_LOAD: begin
        if (in_acc && in_last_i) begin
          state_d = (len_in < TwoCnt) ? nlp_pkg::ST_NONE : nlp_pkg::ST_PV_RD;
        end
      end
      nlp_pkg::ST_PV_RD: state_d = nlp_pkg::ST_PV_CMP;
      nlp_pkg::ST_PV_CMP: begin
        priority if (pv_found) begin
          state_d = nlp_pkg::ST_J_RD;
        end else if (idx_q == '0) begin
          state_d = nlp_pkg::ST_NONE;
        end else begin
          state_d = nlp_pkg::ST_PV_RD;
        end
      end
      nlp_pkg::ST_J_RD: state_d = nlp_pkg::ST_J_CMP;
      nlp_pkg::ST_J_CMP: begin
        state_d = j_found ? nlp_pkg::ST_SW_I : nlp_pkg::ST_J_RD;
      end
      nlp_pkg::ST_SW_I: state_d = nlp_pkg::ST_SW_J;
      nlp_pkg::ST_SW_J: state_d = nlp_pkg::ST_EM_RD;
      nlp_pkg::ST_EM_RD: begin
        if (slot_free_i) begin
          state_d = nlp_pkg::ST_EM_LD;
        end
      end
      nlp_pkg::ST_EM_LD: begin
        state_d = em_last ? nlp_pkg::ST_LOAD : nlp_pkg::ST_EM_RD;
      end
      nlp_pkg::ST_NONE: begin
        if (slot_free_i) begin
          state_d = nlp_pkg::ST_LOAD;
        end
      end
      default: state_d = nlp_pkg::ST_LOAD;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q[ADDR_W-1:0];
    mem_wdata  = in_symbol_i;
    mem_re     = 1'b0;
    mem_raddr  = idx_q;
    res_o      = '0;
    unique case (state_q)
      nlp_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        mem_we     = in_valid_i && has_room;
      end
      nlp_pkg::ST_PV_RD: mem_re = 1'b1;
      nlp_pkg::ST_J_RD: begin
        mem_re    = 1'b1;
        mem_raddr = j_q;
      end
      nlp_pkg::ST_SW_I: begin
        mem_we    = 1'b1;
        mem_waddr = piv_q;
        mem_wdata = sj_val_q;
      end
      nlp_pkg::ST_SW_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = piv_val_q;
      end
      nlp_pkg::ST_EM_RD: begin
        mem_re    = slot_free_i;
        mem_raddr = emit_addr;
      end
      nlp_pkg::ST_EM_LD: begin
        res_o.load   = 1'b1;
        res_o.symbol = rdata_q;
        res_o.last   = em_last;
      end
      nlp_pkg::ST_NONE: begin
        res_o.load = slot_free_i;
        res_o.last = 1'b1;
        res_o.none = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nlp_pkg::ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_q <= in_last_i ? '0 : len_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      nlp_pkg::ST_LOAD: begin
        if (in_acc) begin
          len_q   <= len_in;
          idx_q   <= ADDR_W'(len_in - OneCnt);
          first_q <= 1'b1;
        end
      end
      nlp_pkg::ST_PV_CMP: begin
        first_q <= 1'b0;
        prev_q  <= rdata_q;
        if (pv_found) begin
          piv_q     <= idx_q;
          piv_val_q <= rdata_q;
          j_q       <= ADDR_W'(len_q - OneCnt);
        end else begin
          idx_q <= idx_q - ADDR_W'(1);
        end
      end
      nlp_pkg::ST_J_CMP: begin
        if (j_found) begin
          sj_val_q <= rdata_q;
        end else begin
          j_q <= j_q - ADDR_W'(1);
        end
      end
      nlp_pkg::ST_SW_J: idx_q <= '0;
      nlp_pkg::ST_EM_LD: idx_q <= idx_q + ADDR_W'(1);
      default: begin
        first_q <= first_q;
      end
    endcase
  end

  // Symbol store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  `NLP_ASSERT_IMPL(a_port_excl, mem_we, !mem_re, "store written and read in one cycle")
  `NLP_ASSERT_IMPL(a_j_right, state_q == nlp_pkg::ST_J_CMP, j_q > piv_q, "partner left of pivot")
  `NLP_ASSERT_IMPL(a_emit_range, state_q == nlp_pkg::ST_EM_LD, CNT_W'(idx_q) < len_q,
                   "emit index beyond string")
  `NLP_ASSERT_IMPL(a_res_slot, res_o.load, slot_free_i, "result loaded into a full slot")

endmodule

/* design/nlp_out_reg.sv */
// Output register of the next-permutation core: holds one result until taken.
// Depends on nlp_pkg and the defines header.
`include "next_lexicographic_permutation_core_defines.svh"

module nlp_out_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nlp_pkg::nlp_res_t         res_i,
  output logic                      slot_free_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [nlp_pkg::SYM_W-1:0] symbol_o,
  output logic                      last_o,
  output logic                      none_o
);

  logic valid_q;

  assign valid_o     = valid_q;
  // The slot frees in the same cycle the held transaction is taken.
  assign slot_free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.load) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.load) begin
      symbol_o <= res_i.symbol;
      last_o   <= res_i.last;
      none_o   <= res_i.none;
    end
  end

  `NLP_ASSERT_NEXT(a_load_shows, res_i.load, valid_q, "loaded result not presented")
  `NLP_ASSERT_IMPL(a_none_last, res_i.load && res_i.none, res_i.last && (res_i.symbol == '0),
                   "no-answer result must be last with zero symbol")
  `NLP_ASSERT_NEXT(a_drain, valid_q && ready_i && !res_i.load, !valid_q,
                   "taken result still presented")

endmodule

/* design/next_lexicographic_permutation_core.sv */
// Top level of the next lexicographic permutation core.
// Depends on nlp_pkg, nlp_engine and nlp_out_reg.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[7:0] symbol, tlast last_symbol
//   m_axis   out        tdata[7:0] out_symbol, tlast last_out, tuser[0] no_answer
//
// Loading accepts one symbol per cycle in the load phase; symbols past MAX_LEN
// are dropped. After the last symbol, the pivot and partner scans read and
// then compare one element at a time, the swap writes pivot then partner, and
// each result is read from the store before it is loaded, all bound by the
// single registered read port of the store. When the pivot scan runs out, or
// the string holds a single symbol, the no-answer result is loaded instead.
// Reset is asynchronous and active low; the store needs no clearing.
// A stalled output holds the block in its emit phase; the final result may
// wait in the output register while the next string is already loading.
module next_lexicographic_permutation_core #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [nlp_pkg::SYM_W-1:0] s_axis_tdata_i,   // [7:0] symbol
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [nlp_pkg::SYM_W-1:0] m_axis_tdata_o,   // [7:0] out_symbol
  output logic                      m_axis_tlast_o,
  output logic [0:0]                m_axis_tuser_o    // [0] no_answer
);

  nlp_pkg::nlp_res_t res;
  logic              slot_free;

  nlp_engine #(
    .MAX_LEN (MAX_LEN)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_symbol_i (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .slot_free_i (slot_free),
    .res_o       (res)
  );

  nlp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .slot_free_o (slot_free),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .symbol_o    (m_axis_tdata_o),
    .last_o      (m_axis_tlast_o),
    .none_o      (m_axis_tuser_o[0])
  );

endmodule
